// ===== rtl/core/lftc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lftc_pkg: shared definitions for the stack/queue trace classifier
// Store sizing, command codes and the packed result word.
// ----------------------------------------------------------------------------
package lftc_pkg;

	localparam int STORE_DEPTH = 128;
	localparam int VALUE_WIDTH = 32;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STORE_DEPTH);

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	// lowest bit first: verdict, still_stack, still_queue, overflow, padding
	typedef struct packed {
		logic [2:0] pad;
		logic       overflow;
		logic       still_queue;
		logic       still_stack;
		logic [1:0] verdict;
	} result_t;

endpackage

// ===== rtl/core/lifo_fifo_trace_classifier_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_fifo_trace_classifier_unit: stack/queue trace classifier
// Replays a trace of insert/remove operations on a shadow stack and a shadow
// queue and reports after every operation which of the two still fits.
// ----------------------------------------------------------------------------
// Input stream s_*: one operation per transfer. s_tuser is the command
// (insert or remove), s_tdata the value, s_tlast marks the end of a trace.
// Output stream m_*: one result per operation, in order. m_tdata carries the
// verdict, the two match flags and the sticky overflow flag; m_tlast echoes
// the trace end. After the last operation of a trace all trace state clears.
// The result passes the input register, then the result register. Throughput:
// one operation per cycle while m_tready holds, set by the single store read
// and compare done per operation in the input register stage; the stores'
// registered reads are issued as the operation enters, with the write of the
// operation ahead forwarded.
// Reset empties both register stages and clears the counters and flags; the
// stores themselves need no clearing pass. When the receiver stalls, one
// result waits in the result register and one operation in the input
// register, after which s_tready drops until m_tready returns.
// Inserts beyond the store depth are dropped and raise the overflow flag.
// ----------------------------------------------------------------------------
module lifo_fifo_trace_classifier_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value (signed)
	input  logic [0:0]  s_tuser,   // [0] command
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [1:0] verdict, [2] still_stack, [3] still_queue,
	                               // [4] overflow, [7:5] zero
	output logic        m_tlast
);

	localparam int VW = lftc_pkg::VALUE_WIDTH;
	localparam int AW = lftc_pkg::ADDR_W;
	localparam int CW = lftc_pkg::CNT_W;

	// input register stage
	logic          valid_s1;
	logic          cmd_s1;
	logic [VW-1:0] value_s1;
	logic          last_s1;
	logic          fwd_stk_s1;
	logic          fwd_q_s1;
	logic [VW-1:0] fwd_data_s1;

	// trace state
	logic [CW-1:0] stk_cnt_q;
	logic [CW-1:0] q_head_q;
	logic [CW-1:0] q_tail_q;
	logic          stk_ok_q;
	logic          q_ok_q;
	logic          ovf_q;

	// result register
	logic                  out_valid_q;
	lftc_pkg::result_t     out_data_q;
	logic                  out_last_q;

	logic          adv;
	logic          accept;
	logic          is_push;
	logic [VW-1:0] stk_rdata;
	logic [VW-1:0] q_rdata;
	logic [VW-1:0] stk_top;
	logic [VW-1:0] q_front;

	logic          stk_we;
	logic [AW-1:0] stk_waddr;
	logic          q_we;
	logic [AW-1:0] q_waddr;
	logic [AW-1:0] stk_raddr;
	logic [AW-1:0] q_raddr;
	logic [CW-1:0] stk_dec;

	logic [CW-1:0] stk_cnt_a;
	logic [CW-1:0] q_head_a;
	logic [CW-1:0] q_tail_a;
	logic          stk_ok_a;
	logic          q_ok_a;
	logic          ovf_a;

	logic [CW-1:0] stk_cnt_n;
	logic [CW-1:0] q_head_n;
	logic [CW-1:0] q_tail_n;
	logic          stk_ok_n;
	logic          q_ok_n;
	logic          ovf_n;

	lftc_pkg::result_t res;

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign accept   = s_tvalid && s_tready;
	assign is_push  = (cmd_s1 == lftc_pkg::CMD_INSERT);

	assign stk_top = fwd_stk_s1 ? fwd_data_s1 : stk_rdata;
	assign q_front = fwd_q_s1 ? fwd_data_s1 : q_rdata;

	assign stk_waddr = stk_cnt_q[AW-1:0];
	assign q_waddr   = q_tail_q[AW-1:0];

	always_comb begin
		stk_we    = 1'b0;
		q_we      = 1'b0;
		stk_cnt_a = stk_cnt_q;
		q_head_a  = q_head_q;
		q_tail_a  = q_tail_q;
		stk_ok_a  = stk_ok_q;
		q_ok_a    = q_ok_q;
		ovf_a     = ovf_q;

		if (adv && stk_ok_q) begin
			if (is_push) begin
				if (stk_cnt_q < lftc_pkg::DEPTH_CNT) begin
					stk_we    = 1'b1;
					stk_cnt_a = stk_cnt_q + CW'(1);
				end else begin
					ovf_a = 1'b1;
				end
			end else if (stk_cnt_q == '0) begin
				stk_ok_a = 1'b0;
			end else begin
				stk_cnt_a = stk_cnt_q - CW'(1);
				if (stk_top != value_s1) begin
					stk_ok_a = 1'b0;
				end
			end
		end

		if (adv && q_ok_q) begin
			if (is_push) begin
				if (q_tail_q < lftc_pkg::DEPTH_CNT) begin
					q_we     = 1'b1;
					q_tail_a = q_tail_q + CW'(1);
				end else begin
					ovf_a = 1'b1;
				end
			end else if (q_head_q >= q_tail_q) begin
				q_ok_a = 1'b0;
			end else begin
				q_head_a = q_head_q + CW'(1);
				if (q_front != value_s1) begin
					q_ok_a = 1'b0;
				end
			end
		end

		if (adv && last_s1) begin
			stk_cnt_n = '0;
			q_head_n  = '0;
			q_tail_n  = '0;
			stk_ok_n  = 1'b1;
			q_ok_n    = 1'b1;
			ovf_n     = 1'b0;
		end else begin
			stk_cnt_n = stk_cnt_a;
			q_head_n  = q_head_a;
			q_tail_n  = q_tail_a;
			stk_ok_n  = stk_ok_a;
			q_ok_n    = q_ok_a;
			ovf_n     = ovf_a;
		end
	end

	// read addresses for the operation entering now, seen from the state it will meet
	assign stk_dec   = stk_cnt_n - CW'(1);
	assign stk_raddr = stk_dec[AW-1:0];
	assign q_raddr   = q_head_n[AW-1:0];

	always_comb begin
		res             = '0;
		res.verdict     = {q_ok_a, stk_ok_a};
		res.still_stack = stk_ok_a;
		res.still_queue = q_ok_a;
		res.overflow    = ovf_a;
	end

	lftc_ram #(
		.WIDTH (VW),
		.DEPTH (lftc_pkg::STORE_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (value_s1),
		.re    (accept),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	lftc_ram #(
		.WIDTH (VW),
		.DEPTH (lftc_pkg::STORE_DEPTH)
	) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (value_s1),
		.re    (accept),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			stk_cnt_q   <= '0;
			q_head_q    <= '0;
			q_tail_q    <= '0;
			stk_ok_q    <= 1'b1;
			q_ok_q      <= 1'b1;
			ovf_q       <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			stk_cnt_q <= stk_cnt_n;
			q_head_q  <= q_head_n;
			q_tail_q  <= q_tail_n;
			stk_ok_q  <= stk_ok_n;
			q_ok_q    <= q_ok_n;
			ovf_q     <= ovf_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= s_tuser[0];
			value_s1    <= s_tdata[VW-1:0];
			last_s1     <= s_tlast;
			fwd_stk_s1  <= stk_we && (stk_waddr == stk_raddr);
			fwd_q_s1    <= q_we && (q_waddr == q_raddr);
			fwd_data_s1 <= value_s1;
		end
		if (adv) begin
			out_data_q <= res;
			out_last_q <= last_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	// checks
	a_stk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stk_cnt_q <= lftc_pkg::DEPTH_CNT)
		else $error("stack count beyond store depth");

	a_q_order: assert property (@(posedge clk) disable iff (!arst_n)
		(q_head_q <= q_tail_q) && (q_tail_q <= lftc_pkg::DEPTH_CNT))
		else $error("queue pointers out of order");

	a_trace_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> (stk_cnt_q == '0) && (q_tail_q == '0) && (q_head_q == '0)
			&& stk_ok_q && q_ok_q && !ovf_q)
		else $error("trace state not cleared after last transfer");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> $stable(stk_cnt_q) && $stable(q_tail_q) && $stable(q_head_q))
		else $error("trace state moved while input stage stalled");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(stk_we || q_we) |-> adv && is_push)
		else $error("store written without an advancing insert");

endmodule

// ===== rtl/core/lftc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lftc_ram: generic simple dual-port RAM
// One write port, one read port, registered read returning the old word on a
// same-address write.
// ----------------------------------------------------------------------------
module lftc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
